/* hdl/cfr_pkg.sv */
package cfr_pkg;

  localparam int DEF_PAYLOAD_BYTES = 40;
  localparam int MAX_WORDS         = 10;

  localparam logic [7:0]  HEADER_MARK  = 8'h55;
  localparam logic [7:0]  TRAILER_MARK = 8'hAA;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_TOP      = 16'h8000;

  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_BAD_FRAME = 2'd1;
  localparam logic [1:0] ST_BAD_CRC   = 2'd2;

  // crc16-ccitt, msb first, one byte
  function automatic logic [15:0] cfr_crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/cfr_ram.sv */
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/crc_checked_feedback_frame_receiver_top.sv */
// channel | direction | fields                                        | handshake
// in_     | input     | rx_byte[7:0]                                  | in_valid / in_stall
// out_    | output    | status[1:0] word_index[3:0] word_value[31:0] last | out_valid / out_stall
//
// one byte per cycle is taken while no word burst is running.
// the final byte of a good frame starts a burst: each word takes four payload ram reads,
// a drain state to collect the last byte and a put state that loads the output once it is free,
// input stalled meanwhile; a frame is 44 bytes at the default size.
// synchronous active-low reset restarts the frame count; the payload ram needs no clearing.
// out_stall holds the output register; the final byte of a frame waits for it to empty.
module crc_checked_feedback_frame_receiver_top #(
  parameter int PAYLOAD_BYTES = cfr_pkg::DEF_PAYLOAD_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_word_index,
  output logic [31:0] out_word_value,
  output logic        out_last
);
  import cfr_pkg::*;

  localparam int PW = $clog2(PAYLOAD_BYTES + 4);
  localparam int AW = $clog2(PAYLOAD_BYTES);
  localparam int WordCount = (PAYLOAD_BYTES / 4 > MAX_WORDS) ? MAX_WORDS : PAYLOAD_BYTES / 4;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_DRAIN, S_PUT} state_t;

  state_t        state_r;
  logic [PW-1:0] pos_r;
  logic [15:0]   crc_r;
  logic          hdr_ok_r;
  logic [7:0]    crc_hi_r;
  logic [3:0]    word_r;
  logic [1:0]    sub_r;
  logic [1:0]    pend_sub_r;
  logic          pend_r;
  logic [AW-1:0] rd_addr_r;
  logic [7:0]    asm_r [4];

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [3:0]    out_index_r;
  logic [31:0]   out_value_r;
  logic          out_last_r;

  logic          in_accept;
  logic          last_byte;
  logic          out_free;
  logic [15:0]   crc_fed;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;
  logic [PW-1:0] pos_dec;

  assign last_byte = pos_r == PW'(PAYLOAD_BYTES + 3);
  assign in_stall  = (state_r != S_IDLE) || (last_byte && out_valid_r);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign crc_fed   = cfr_crc_feed(crc_r, in_rx_byte);
  assign pos_dec   = pos_r - PW'(1);
  assign ram_waddr = pos_dec[AW-1:0];
  assign ram_we    = in_accept && (pos_r != '0) && (pos_r <= PW'(PAYLOAD_BYTES));

  cfr_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_rx_byte),
    .re   (state_r == S_FETCH),
    .raddr(rd_addr_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      hdr_ok_r    <= 1'b0;
      crc_hi_r    <= 8'h00;
      word_r      <= 4'd0;
      sub_r       <= 2'd0;
      pend_r      <= 1'b0;
      rd_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= state_r == S_FETCH;
      if (pend_r) begin
        asm_r[pend_sub_r] <= ram_rdata;
      end
      // the word load in S_PUT sets valid itself
      if (out_valid_r && !out_stall && state_r != S_PUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (pos_r == '0) begin
              hdr_ok_r <= in_rx_byte == HEADER_MARK;
              pos_r    <= pos_r + PW'(1);
            end else if (pos_r <= PW'(PAYLOAD_BYTES)) begin
              crc_r <= crc_fed;
              pos_r <= pos_r + PW'(1);
            end else if (pos_r == PW'(PAYLOAD_BYTES + 1)) begin
              crc_hi_r <= in_rx_byte;
              pos_r    <= pos_r + PW'(1);
            end else if (pos_r == PW'(PAYLOAD_BYTES + 2)) begin
              // zero afterwards means the received crc matches
              crc_r <= crc_r ^ {crc_hi_r, in_rx_byte};
              pos_r <= pos_r + PW'(1);
            end else begin
              pos_r    <= '0;
              crc_r    <= CRC_INIT;
              hdr_ok_r <= 1'b0;
              crc_hi_r <= 8'h00;
              if (!hdr_ok_r || in_rx_byte != TRAILER_MARK) begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_BAD_FRAME;
                out_index_r  <= 4'd0;
                out_value_r  <= 32'd0;
                out_last_r   <= 1'b1;
              end else if (crc_r != 16'h0000) begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_BAD_CRC;
                out_index_r  <= 4'd0;
                out_value_r  <= 32'd0;
                out_last_r   <= 1'b1;
              end else begin
                state_r   <= S_FETCH;
                word_r    <= 4'd0;
                sub_r     <= 2'd0;
                rd_addr_r <= '0;
              end
            end
          end
        end
        S_FETCH: begin
          pend_sub_r <= sub_r;
          sub_r      <= sub_r + 2'd1;
          rd_addr_r  <= rd_addr_r + AW'(1);
          if (sub_r == 2'd3) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // top byte of the word lands this cycle
          state_r <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_GOOD;
            out_index_r  <= word_r;
            out_value_r  <= {asm_r[3], asm_r[2], asm_r[1], asm_r[0]};
            out_last_r   <= word_r == 4'(WordCount - 1);
            if (word_r == 4'(WordCount - 1)) begin
              state_r <= S_IDLE;
            end else begin
              word_r  <= word_r + 4'd1;
              state_r <= S_FETCH;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_word_index = out_index_r;
  assign out_word_value = out_value_r;
  assign out_last       = out_last_r;

endmodule

/* hdl/cfr_checker.sv */
module cfr_checker #(
  parameter int PAYLOAD_BYTES = cfr_pkg::DEF_PAYLOAD_BYTES
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [3:0]  out_word_index,
  input logic [31:0] out_word_value,
  input logic        out_last
);
  import cfr_pkg::*;

  localparam int WordCount = (PAYLOAD_BYTES / 4 > MAX_WORDS) ? MAX_WORDS : PAYLOAD_BYTES / 4;

  logic in_seen;
  assign in_seen = in_valid && !in_stall && (in_rx_byte != 8'h00 || in_rx_byte == 8'h00);

  // held result transaction keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_word_index)
      && $stable(out_word_value) && $stable(out_last))
    else $error("stalled result changed");

  // error status is a single closing transaction with zero payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_GOOD |-> out_last && out_word_index == 4'd0
      && out_word_value == 32'd0 && (out_status == ST_BAD_FRAME || out_status == ST_BAD_CRC))
    else $error("malformed error result");

  // last flag marks exactly the final word of a good frame
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_GOOD |->
      out_last == (out_word_index == 4'(WordCount - 1)))
    else $error("last flag on wrong word");

  // a good word that is taken and not last is followed by the next index
  assert property (@(posedge clk) disable iff (!rst_n || in_seen)
    out_valid && !out_stall && out_status == ST_GOOD && !out_last ##1 out_valid |->
      out_word_index == $past(out_word_index) + 4'd1)
    else $error("word index out of sequence");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind crc_checked_feedback_frame_receiver_top cfr_checker #(
  .PAYLOAD_BYTES(PAYLOAD_BYTES)
) u_cfr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_rx_byte    (in_rx_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_word_index(out_word_index),
  .out_word_value(out_word_value),
  .out_last      (out_last)
);

/* tb/cfr_frame_checker.sv */
`timescale 1ns / 100ps

module cfr_frame_checker #(
  parameter int PAYLOAD_BYTES = cfr_pkg::DEF_PAYLOAD_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_word_index,
  input  logic [31:0] out_word_value,
  input  logic        out_last,
  output int          fail_count,
  output int          outstanding
);
  import cfr_pkg::*;

  localparam int WORDS_PER_FRAME =
    (PAYLOAD_BYTES / 4 > MAX_WORDS) ? MAX_WORDS : PAYLOAD_BYTES / 4;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
  } frame_word_t;

  frame_word_t expected_words[$];

  int unsigned byte_pos;
  logic [15:0] crc_acc;
  logic        header_seen_ok;
  logic [7:0]  crc_rx_high;
  logic [7:0]  payload_mem [PAYLOAD_BYTES];
  int          mismatch_total;

  // bitwise form, msb first, no reflection
  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void add_expected(input frame_word_t w);
    expected_words = {expected_words, w};
  endfunction

  task automatic clear_frame_state();
    byte_pos       = 0;
    crc_acc        = CRC_INIT;
    header_seen_ok = 1'b0;
    crc_rx_high    = 8'h00;
  endtask

  task automatic take_frame_byte(input logic [7:0] b);
    frame_word_t w;
    if (byte_pos == 0) begin
      header_seen_ok = (b == HEADER_MARK);
      byte_pos++;
    end else if (byte_pos <= PAYLOAD_BYTES) begin
      payload_mem[byte_pos - 1] = b;
      crc_acc = crc16_ccitt_byte(crc_acc, b);
      byte_pos++;
    end else if (byte_pos == PAYLOAD_BYTES + 1) begin
      crc_rx_high = b;
      byte_pos++;
    end else if (byte_pos == PAYLOAD_BYTES + 2) begin
      // zero after this means the received crc matches
      crc_acc = crc_acc ^ {crc_rx_high, b};
      byte_pos++;
    end else begin
      // header and trailer take priority over the crc
      if (!header_seen_ok || b != TRAILER_MARK) begin
        w = {ST_BAD_FRAME, 4'd0, 32'd0, 1'b1};
        add_expected(w);
      end else if (crc_acc != 16'h0000) begin
        w = {ST_BAD_CRC, 4'd0, 32'd0, 1'b1};
        add_expected(w);
      end else begin
        for (int k = 0; k < WORDS_PER_FRAME; k++) begin
          w.status = ST_GOOD;
          w.index  = 4'(k);
          w.value  = {payload_mem[4 * k + 3], payload_mem[4 * k + 2],
                      payload_mem[4 * k + 1], payload_mem[4 * k]};
          w.last   = (k == WORDS_PER_FRAME - 1);
          add_expected(w);
        end
      end
      clear_frame_state();
    end
  endtask

  always @(posedge clk) begin
    frame_word_t want;
    frame_word_t got;
    if (!rst_n) begin
      clear_frame_state();
      expected_words.delete();
      mismatch_total = 0;
    end else begin
      if (in_valid && !in_stall) begin
        take_frame_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        got = {out_status, out_word_index, out_word_value, out_last};
        if (expected_words.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("%0t: unexpected transaction: status=%0d index=%0d value=%h last=%0d",
                     $realtime, got.status, got.index, got.value, got.last);
          end
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("%0t: mismatch: expected status=%0d index=%0d value=%h last=%0d",
                       $realtime, want.status, want.index, want.value, want.last);
              $display("%0t:           got      status=%0d index=%0d value=%h last=%0d",
                       $realtime, got.status, got.index, got.value, got.last);
            end
          end
        end
      end
    end
    fail_count  <= mismatch_total;
    outstanding <= expected_words.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cfr_pkg::*;

  localparam int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES;
  localparam int HOLD_CYCLES   = 400;
  localparam int STUCK_LIMIT   = 5000;
  localparam int TAIL_CYCLES   = 80;
  localparam int FRAMES_PER_PHASE = 1;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_HEADER,
    FRAME_BAD_TRAILER,
    FRAME_BAD_CRC,
    FRAME_BAD_HEADER_CRC,
    FRAME_NOISE
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_word_index;
  logic [31:0] out_word_value;
  logic        out_last;

  int fail_count;
  int outstanding;
  int send_idle_pct = 19;
  int recv_idle_pct = 62;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  logic [7:0] payload_buf [PAYLOAD_BYTES];

  crc_checked_feedback_frame_receiver_top #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_last       (out_last)
  );

  cfr_frame_checker #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) frame_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STUCK_LIMIT) begin
      $display("** crc_checked_feedback_frame_receiver_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver side, with one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [15:0] crc;
    logic [7:0]  head;
    logic [7:0]  tail;
    crc  = CRC_INIT;
    head = HEADER_MARK;
    tail = TRAILER_MARK;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      crc = cfr_crc_feed(crc, payload_buf[i]);
    end
    if (kind == FRAME_BAD_HEADER || kind == FRAME_BAD_HEADER_CRC) begin
      do head = 8'($urandom); while (head == HEADER_MARK);
    end
    if (kind == FRAME_BAD_TRAILER) begin
      do tail = 8'($urandom); while (tail == TRAILER_MARK);
    end
    if (kind == FRAME_BAD_CRC || kind == FRAME_BAD_HEADER_CRC) begin
      crc = crc ^ 16'($urandom_range(16'hFFFF, 1));
    end
    if (kind == FRAME_NOISE) begin
      // whole frame of line noise keeps the byte count aligned
      for (int i = 0; i < PAYLOAD_BYTES + 4; i++) begin
        send_byte(8'($urandom));
      end
    end else begin
      send_byte(head);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        send_byte(payload_buf[i]);
      end
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
      send_byte(tail);
    end
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 60) return FRAME_GOOD;
    if (r < 70) return FRAME_BAD_HEADER;
    if (r < 80) return FRAME_BAD_TRAILER;
    if (r < 90) return FRAME_BAD_CRC;
    if (r < 95) return FRAME_BAD_HEADER_CRC;
    return FRAME_NOISE;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames: all-ones payload, then bad header and bad crc together
    foreach (payload_buf[i]) payload_buf[i] = 8'hFF;
    send_frame(FRAME_GOOD);
    foreach (payload_buf[i]) payload_buf[i] = 8'(i * 37 + (i % 2) * 8'h80);
    payload_buf[0] = 8'h00;
    send_frame(FRAME_BAD_HEADER_CRC);

    // let the block drain completely before the random part
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    for (int p = 0; p < 3; p++) begin
      if (p == 0) begin
        send_idle_pct = 19;
        recv_idle_pct = 62;
        hold_req = 1'b1;
      end else if (p == 1) begin
        send_idle_pct = 62;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
        foreach (payload_buf[i]) payload_buf[i] = 8'($urandom);
        // good, random in phase 1; the phase 0 hold-off backs up the burst
        send_frame((p == 1) ? pick_kind() : FRAME_GOOD);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** crc_checked_feedback_frame_receiver_top: PASSED **");
    end else begin
      $display("** crc_checked_feedback_frame_receiver_top: FAILED **");
    end
    $finish;
  end

endmodule
